@@ hdl/pte_pkg.sv @@
// ----------------------------------------------------------------------------
// pte_pkg
// Shared widths, register indexes, state encodings and the job record passed
// from the word front end to the phase back end.
// ----------------------------------------------------------------------------
package pte_pkg;

	localparam int unsigned PAYLOAD_W   = 24;
	localparam int unsigned FRAC_W      = 2 * PAYLOAD_W;
	localparam int unsigned PHASE_W     = 47;
	localparam int unsigned WORK_W      = 53;
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 47;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [47:0] SUBNS_SECOND_DEF = 48'd65536000000000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_BOTH_EDGES   = 1'b0,
		CFG_PHASE_OFFSET = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		POS_FIRST,
		POS_SECOND,
		POS_THIRD,
		POS_FOURTH
	} word_pos_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SWEEP,
		BK_FINAL,
		BK_DONE
	} back_state_t;

	typedef struct packed {
		logic              ok;
		logic [FRAC_W-1:0] subns;
	} job_t;

endpackage

@@ hdl/pte_word_if.sv @@
// ----------------------------------------------------------------------------
// pte_word_if
// Timestamp FIFO word channel: flags and payload with valid/ready.
// ----------------------------------------------------------------------------
interface pte_word_if import pte_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 word_last;
	logic                 word_valid;
	logic [PAYLOAD_W-1:0] word_payload;

	modport source(output valid, word_last, word_valid, word_payload, input ready);
	modport sink(input valid, word_last, word_valid, word_payload, output ready);
endinterface

@@ hdl/pte_result_if.sv @@
// ----------------------------------------------------------------------------
// pte_result_if
// Result channel: descriptor status and phase correction with valid/ready.
// ----------------------------------------------------------------------------
interface pte_result_if import pte_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      descriptor_ok;
	logic signed [PHASE_W-1:0] phase_correction;

	modport source(output valid, descriptor_ok, phase_correction, input ready);
	modport sink(input valid, descriptor_ok, phase_correction, output ready);
endinterface

@@ hdl/pte_front.sv @@
// ----------------------------------------------------------------------------
// pte_front
// Groups FIFO words into four-word descriptors, checks the flags and pushes
// one job per completed descriptor into the queue.
// ----------------------------------------------------------------------------
module pte_front import pte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pte_word_if.sink   word,
	input  logic       full,
	output logic       push,
	output job_t       push_job
);

	word_pos_t            pos_q, pos_d;
	logic                 middle_valid_q;
	logic [PAYLOAD_W-1:0] upper_q;
	logic                 accept;

	assign accept = word.valid && word.ready;

	// next position
	always_comb begin
		pos_d = pos_q;
		unique case (pos_q)
			POS_FIRST:  if (accept && word.word_valid) pos_d = POS_SECOND;
			POS_SECOND: if (accept) pos_d = POS_THIRD;
			POS_THIRD:  if (accept) pos_d = POS_FOURTH;
			POS_FOURTH: if (accept) pos_d = POS_FIRST;
		endcase
	end

	// outputs: stall only the closing word when the queue is full
	always_comb begin
		word.ready     = !((pos_q == POS_FOURTH) && full);
		push           = accept && (pos_q == POS_FOURTH);
		push_job.ok    = middle_valid_q && word.word_last;
		push_job.subns = {upper_q, word.word_payload};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= POS_FIRST;
			middle_valid_q <= 1'b0;
		end else begin
			pos_q <= pos_d;
			if (accept) begin
				unique case (pos_q)
					POS_FIRST:  if (word.word_valid) middle_valid_q <= 1'b1;
					POS_SECOND: middle_valid_q <= middle_valid_q && word.word_valid;
					POS_THIRD:  middle_valid_q <= middle_valid_q && word.word_valid;
					POS_FOURTH: middle_valid_q <= 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (pos_q == POS_THIRD)) begin
			upper_q <= word.word_payload;
		end
	end

endmodule

@@ hdl/pte_queue.sv @@
// ----------------------------------------------------------------------------
// pte_queue
// Short job queue between the front end and the phase back end.
// ----------------------------------------------------------------------------
module pte_queue import pte_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t pop_job,
	output logic empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_job  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/pte_back.sv @@
// ----------------------------------------------------------------------------
// pte_back
// Subtracts the offset, folds the phase into one period by a binary sweep of
// shifted periods, negates it and holds the result in an output register.
// ----------------------------------------------------------------------------
module pte_back import pte_pkg::*; #(
	parameter logic [47:0] SUBNS_SECOND = SUBNS_SECOND_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      empty,
	input  job_t                      pop_job,
	output logic                      pop,
	input  logic                      both_edges,
	input  logic signed [PHASE_W-1:0] phase_offset,
	pte_result_if.source              result
);

	// Bound on the number of whole periods to remove (shortest period).
	localparam logic [47:0]     PMIN  = SUBNS_SECOND >> 1;
	localparam longint unsigned NMAX  = (64'd1 << 49) / PMIN + 1;
	localparam int unsigned     STEPS = $clog2(NMAX + 1);
	localparam int unsigned     CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	back_state_t              state_q, state_d;
	logic signed [WORK_W-1:0] phase_q, div_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     ok_q;
	logic                     res_valid_q;
	logic                     res_ok_q;
	logic signed [PHASE_W-1:0] res_corr_q;

	logic signed [WORK_W-1:0] period_w, half_w, diff_w, neg_w, start_w;
	logic                     slot_free, load_out;

	assign period_w  = WORK_W'(SUBNS_SECOND >> both_edges);
	assign half_w    = period_w >>> 1;
	assign diff_w    = phase_q - div_q;
	assign neg_w     = -phase_q;
	assign start_w   = WORK_W'(pop_job.subns) - WORK_W'(phase_offset);
	assign slot_free = !res_valid_q || result.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!empty) state_d = pop_job.ok ? BK_SWEEP : BK_DONE;
			end
			BK_SWEEP: begin
				if (cnt_q == '0) state_d = BK_FINAL;
			end
			BK_FINAL: state_d = BK_DONE;
			BK_DONE: begin
				if (slot_free) state_d = BK_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		pop      = (state_q == BK_IDLE) && !empty;
		load_out = (state_q == BK_DONE) && slot_free;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				ok_q    <= pop_job.ok;
				phase_q <= pop_job.ok ? start_w : '0;
				div_q   <= period_w <<< (STEPS - 1);
				cnt_q   <= CNT_W'(STEPS - 1);
			end
			BK_SWEEP: begin
				// take a multiple of the period while the phase stays above half
				if (diff_w > half_w) phase_q <= diff_w;
				div_q <= div_q >>> 1;
				cnt_q <= cnt_q - 1'b1;
			end
			BK_FINAL: begin
				if (phase_q > half_w) phase_q <= phase_q - period_w;
			end
			BK_DONE: ;
		endcase
		if (load_out) begin
			res_ok_q   <= ok_q;
			res_corr_q <= neg_w[PHASE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid            = res_valid_q;
	assign result.descriptor_ok    = res_ok_q;
	assign result.phase_correction = res_corr_q;

endmodule

@@ hdl/pps_timestamp_phase_error_top.sv @@
// ----------------------------------------------------------------------------
// pps_timestamp_phase_error_top
// Pulse-timestamp phase error detector.
//
// The word channel takes timestamp FIFO words (last, valid, 24-bit payload)
// one beat at a time; every four words after a valid first word form one
// descriptor, and the result channel gives one beat per descriptor: an ok
// flag and the negated phase error folded into one period. An invalid first
// word is dropped without a result.
// Words are taken at one per cycle; only the closing word of a descriptor
// stalls, and only while the two-entry job queue is full.
// The back end loads a job, sweeps the phase with its shared
// subtract-and-compare, folds it once more and moves the result into the
// output register, and only then takes the next job. A job with bad flags
// skips the sweep and the fold.
// A stalled result holds in the output register; the back end waits, the
// queue fills and then the front end holds the closing word.
// Reset clears the word position, the queue, the back end and the
// configuration (single-edge period, zero offset). Write configuration only
// while no descriptor is in flight.
// ----------------------------------------------------------------------------
module pps_timestamp_phase_error_top import pte_pkg::*; #(
	parameter logic [47:0] SUBNS_SECOND = SUBNS_SECOND_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	pte_word_if.sink               word,
	pte_result_if.source           result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	logic                      both_edges_q;
	logic signed [PHASE_W-1:0] phase_offset_q;

	logic push, full, pop, empty;
	job_t push_job, pop_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			both_edges_q   <= 1'b0;
			phase_offset_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_BOTH_EDGES:   both_edges_q   <= cfg_wdata[0];
				CFG_PHASE_OFFSET: phase_offset_q <= signed'(cfg_wdata[PHASE_W-1:0]);
			endcase
		end
	end

	pte_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.word     (word),
		.full     (full),
		.push     (push),
		.push_job (push_job)
	);

	pte_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (empty)
	);

	pte_back #(
		.SUBNS_SECOND (SUBNS_SECOND)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.pop_job      (pop_job),
		.pop          (pop),
		.both_edges   (both_edges_q),
		.phase_offset (phase_offset_q),
		.result       (result)
	);

endmodule

@@ bench/pte_phase_checker.sv @@
// ----------------------------------------------------------------------------
// pte_phase_checker
// Watches the word, result and register ports of the phase error detector.
// Tracks descriptor assembly and register settings on its own, works out the
// expected ok flag and phase correction of every closing word, and compares
// each result beat against the oldest expectation.
// ----------------------------------------------------------------------------
module pte_phase_checker import pte_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	pte_word_if                    word,
	pte_result_if                  result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	output int                     errors,
	output int                     pending,
	output int                     checked,
	output logic                   frame_start
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic               ok;
		logic [PHASE_W-1:0] corr;
	} correction_t;

	correction_t               expected_corrections[$];
	logic                      edge_mode;
	logic signed [PHASE_W-1:0] offset_q;
	word_pos_t                 pos;
	logic                      mid_ok;
	logic [PAYLOAD_W-1:0]      upper;
	int                        fail_count;
	int                        match_count;

	// Fold the offset-corrected stamp into one period and negate it.
	function automatic logic [PHASE_W-1:0] predict_correction(input logic [FRAC_W-1:0] stamp);
		longint span;
		longint half;
		longint ph;
		longint n;
		span = longint'(SUBNS_SECOND_DEF) >> edge_mode;
		half = span / 2;
		ph = longint'(stamp) - longint'(offset_q);
		if (ph > half) begin
			n = (ph - half + span - 1) / span;
			ph = ph - n * span;
		end
		return PHASE_W'(-ph);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		correction_t got;
		correction_t want;
		logic        ok;
		if (!arst_n) begin
			edge_mode = 1'b0;
			offset_q = '0;
			pos = POS_FIRST;
			mid_ok = 1'b0;
			upper = '0;
			fail_count = 0;
			match_count = 0;
			expected_corrections.delete();
			errors <= 0;
			pending <= 0;
			checked <= 0;
			frame_start <= 1'b1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_BOTH_EDGES:   edge_mode = cfg_wdata[0];
					CFG_PHASE_OFFSET: offset_q = cfg_wdata;
					default: ;
				endcase
			end

			if (result.valid && result.ready) begin
				got = {result.descriptor_ok, result.phase_correction};
				if (expected_corrections.size() == 0) begin
					fail_count++;
					$display("%0t: result beat with nothing expected: ok=%0d correction=%0d",
						$time, got.ok, $signed(got.corr));
				end else begin
					want = expected_corrections.pop_front();
					match_count++;
					if (got.ok !== want.ok) begin
						fail_count++;
						$display("%0t: descriptor_ok expected %0d, got %0d",
							$time, want.ok, got.ok);
					end
					if (got.corr !== want.corr) begin
						fail_count++;
						$display("%0t: phase_correction expected %0d, got %0d",
							$time, $signed(want.corr), $signed(got.corr));
					end
				end
			end

			if (word.valid && word.ready) begin
				case (pos)
					POS_FIRST: begin
						// drop an invalid first word, keep waiting
						if (word.word_valid) begin
							pos = POS_SECOND;
							mid_ok = 1'b1;
						end
					end
					POS_SECOND: begin
						mid_ok = mid_ok && word.word_valid;
						pos = POS_THIRD;
					end
					POS_THIRD: begin
						mid_ok = mid_ok && word.word_valid;
						upper = word.word_payload;
						pos = POS_FOURTH;
					end
					default: begin
						ok = mid_ok && word.word_last;
						want.ok = ok;
						want.corr = ok ? predict_correction({upper, word.word_payload}) : '0;
						expected_corrections.push_back(want);
						pos = POS_FIRST;
						mid_ok = 1'b0;
					end
				endcase
			end

			errors <= fail_count;
			pending <= expected_corrections.size();
			checked <= match_count;
			frame_start <= (pos == POS_FIRST);
		end
	end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the pulse-timestamp phase error detector.
// Sends a directed set of descriptors (invalid first word, a zero stamp,
// the half-period boundary, broken flags), then random descriptors with
// noise under a series of register settings, with random gaps and stalls on
// both channels and a long result hold-off. Checking is left to the checker.
// ----------------------------------------------------------------------------
module tb;
	import pte_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint SECOND      = longint'(SUBNS_SECOND_DEF);
	localparam int     ITEM_TARGET = 1870;
	localparam int     PHASE_ITEMS = 180;
	localparam int     CYCLE_LIMIT = 400000;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	int     chk_errors;
	int     chk_pending;
	int     chk_checked;
	logic   frame_start;

	bit     quiet;
	bit     hold_long;
	bit     cur_edge;
	longint cur_offset;
	int     items_sent;
	int     settings_used;
	int     cycle_count = 0;

	pte_word_if   word_ch();
	pte_result_if result_ch();

	pps_timestamp_phase_error_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.word      (word_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	pte_phase_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.word        (word_ch),
		.result      (result_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.errors      (chk_errors),
		.pending     (chk_pending),
		.checked     (chk_checked),
		.frame_start (frame_start)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic bit rare(input int n);
		return $urandom_range(0, n - 1) == 0;
	endfunction

	// Random stamp, one close to the fold boundary of the current setting, or all zeros or all ones.
	function automatic logic [FRAC_W-1:0] pick_stamp();
		longint span;
		longint t;
		int     sel;
		sel = $urandom_range(0, 9);
		span = SECOND >> cur_edge;
		if (sel < 5)
			return FRAC_W'({$urandom, $urandom});
		if (sel < 9) begin
			t = cur_offset + longint'($urandom_range(0, 5)) * span + span / 2
				+ longint'($urandom_range(0, 6)) - 3;
			return FRAC_W'(t);
		end
		return rare(2) ? '0 : '1;
	endfunction

	function automatic longint pick_offset();
		longint unsigned raw;
		raw = {$urandom, $urandom};
		return longint'(raw % (2 * SECOND + 1)) - SECOND;
	endfunction

	task automatic send_word(input bit last, input bit vld, input logic [PAYLOAD_W-1:0] pay);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			word_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		word_ch.valid <= 1'b1;
		word_ch.word_last <= last;
		word_ch.word_valid <= vld;
		word_ch.word_payload <= pay;
		@(posedge clk);
		while (!word_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_frame(input logic [FRAC_W-1:0] ts, input bit v2, input bit v3,
		input bit l4);
		send_word(1'b0, 1'b1, PAYLOAD_W'($urandom));
		send_word(1'b0, v2, PAYLOAD_W'($urandom));
		send_word(1'b0, v3, ts[FRAC_W-1:PAYLOAD_W]);
		send_word(l4, 1'b1, ts[PAYLOAD_W-1:0]);
	endtask

	// Mostly well-formed descriptors; a stray word now and then shifts framing.
	task automatic send_random_frame();
		logic [FRAC_W-1:0] ts;
		if (rare(10)) begin
			send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				PAYLOAD_W'($urandom));
		end else begin
			ts = pick_stamp();
			send_word(rare(8), 1'b1, PAYLOAD_W'($urandom));
			send_word(rare(8), !rare(12), PAYLOAD_W'($urandom));
			send_word(rare(8), !rare(12), ts[FRAC_W-1:PAYLOAD_W]);
			send_word(!rare(12), 1'($urandom_range(0, 1)), ts[PAYLOAD_W-1:0]);
		end
	endtask

	// Finish any partial descriptor, then let every result drain.
	task automatic drain();
		word_ch.valid <= 1'b0;
		@(posedge clk);
		while (!frame_start) begin
			send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				PAYLOAD_W'($urandom));
			word_ch.valid <= 1'b0;
			@(posedge clk);
		end
		while (chk_pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input bit edge_sel, input longint offset);
		write_reg(CFG_BOTH_EDGES, CFG_DATA_W'(edge_sel));
		write_reg(CFG_PHASE_OFFSET, CFG_DATA_W'(offset));
		cur_edge = edge_sel;
		cur_offset = offset;
		settings_used++;
	endtask

	// Result side: random stalls, none in quiet phases, one long hold-off.
	initial begin
		int wait_cycles;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_long) begin
				hold_long = 1'b0;
				wait_cycles = 150;
			end else begin
				wait_cycles = quiet ? 0 : $urandom_range(0, 9);
			end
			if (wait_cycles > 0) begin
				result_ch.ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid) @(posedge clk);
		end
	end

	initial begin
		int phase_no;
		int phase_end;
		word_ch.valid <= 1'b0;
		word_ch.word_last <= 1'b0;
		word_ch.word_valid <= 1'b0;
		word_ch.word_payload <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_BOTH_EDGES;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		quiet = 1'b0;
		hold_long = 1'b0;
		cur_edge = 1'b0;
		cur_offset = 0;
		items_sent = 0;
		settings_used = 1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// invalid first word is dropped
		send_word(1'b1, 1'b0, '1);
		send_frame('0, 1'b1, 1'b1, 1'b1);
		// last flags on early words and valid on the closing word are ignored
		send_word(1'b1, 1'b1, '1);
		send_word(1'b1, 1'b1, '1);
		send_word(1'b1, 1'b1, '1);
		send_word(1'b1, 1'b0, '1);
		// exactly half a period stays, one above folds
		send_frame(FRAC_W'(SECOND / 2), 1'b1, 1'b1, 1'b1);
		send_frame(FRAC_W'(SECOND / 2 + 1), 1'b1, 1'b1, 1'b1);
		// broken descriptors: second word invalid, closing word not last
		send_frame(pick_stamp(), 1'b0, 1'b1, 1'b1);
		send_frame(pick_stamp(), 1'b1, 1'b1, 1'b0);

		phase_no = 0;
		while (items_sent < ITEM_TARGET) begin
			if (phase_no > 0) begin
				drain();
				case (phase_no)
					1: apply_setting(1'b1, 0);
					2: apply_setting(1'b0, SECOND);
					3: apply_setting(1'b1, -SECOND);
					4: apply_setting(1'b0, -SECOND);
					5: apply_setting(1'b1, SECOND);
					default: apply_setting(1'($urandom_range(0, 1)), pick_offset());
				endcase
			end
			quiet = (phase_no % 3 == 1);
			// back up the result side while words keep coming
			if (phase_no == 1)
				hold_long = 1'b1;
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end && items_sent < ITEM_TARGET)
				send_random_frame();
			phase_no++;
		end
		drain();

		$display("checked %0d descriptor results from %0d words under %0d register settings",
			chk_checked, items_sent, settings_used);
		$display("both period modes, offsets at both range ends, fold boundaries, back-pressure");
		if (chk_errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ files.f @@
hdl/pte_pkg.sv
hdl/pte_word_if.sv
hdl/pte_result_if.sv
hdl/pte_front.sv
hdl/pte_queue.sv
hdl/pte_back.sv
hdl/pps_timestamp_phase_error_top.sv
bench/pte_phase_checker.sv
bench/tb.sv
